// ===== src/cll_pkg.sv =====
// Shared constants, codes, types and helpers of the cursor-linked list engine.
// Used by the interfaces, the link store and the engine; depends on nothing.
package cll_pkg;

  localparam int SLOTS  = 64;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int LINK_W = $clog2(SLOTS + 2);
  localparam int OP_W   = 2;
  localparam int POS_W  = 7;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;
  localparam int CNT_W  = 6;

  localparam logic [LINK_W-1:0] END_MARK  = LINK_W'(SLOTS);
  localparam logic [LINK_W-1:0] FREE_MARK = LINK_W'(SLOTS + 1);

  typedef enum logic [OP_W-1:0] {
    OP_INSERT   = 2'd0,
    OP_DELETE   = 2'd1,
    OP_CLEAR    = 2'd2,
    OP_RESERVED = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_POS_ZERO = 2'd1,
    ST_FULL     = 2'd2,
    ST_BEYOND   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FREE,
    S_WALK,
    S_INS_A,
    S_INS_B,
    S_DEL_WR1,
    S_DEL_WR2,
    S_DONE
  } state_t;

  typedef struct packed {
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    logic [LINK_W-1:0] wr_data;
    logic              clear;
  } link_req_t;

  // Successor of a raw link; slot zero and anything outside the store count as the end.
  function automatic logic [LINK_W-1:0] next_of(input logic [LINK_W-1:0] raw);
    logic [LINK_W-1:0] res;
    res = raw;
    if (raw == '0 || raw >= LINK_W'(SLOTS)) begin
      res = END_MARK;
    end
    return res;
  endfunction

endpackage

// ===== src/cll_in_if.sv =====
// Request channel of the list engine: valid, ready and one operation per beat.
// Depends on cll_pkg.
interface cll_in_if;
  logic                        valid;
  logic                        ready;
  logic [cll_pkg::OP_W-1:0]    operation;
  logic [cll_pkg::POS_W-1:0]   position;
  logic signed [cll_pkg::VAL_W-1:0] value;

  modport source (output valid, output operation, output position, output value,
                  input ready);
  modport sink (input valid, input operation, input position, input value,
                output ready);
endinterface

// ===== src/cll_out_if.sv =====
// Result channel of the list engine: valid, ready and one result per beat.
// Depends on cll_pkg.
interface cll_out_if;
  logic                              valid;
  logic                              ready;
  logic [cll_pkg::STAT_W-1:0]        status;
  logic signed [cll_pkg::VAL_W-1:0]  removed_value;
  logic [cll_pkg::CNT_W-1:0]         list_length;
  logic                              is_empty;

  modport source (output valid, output status, output removed_value,
                  output list_length, output is_empty, input ready);
  modport sink (input valid, input status, input removed_value,
                input list_length, input is_empty, output ready);
endinterface

// ===== src/cll_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
// Depends on nothing.
module cll_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/cll_link_store.sv =====
// Link store: a RAM of successor links with per-slot valid bits, so that an
// unwritten slot reads as its reset layout and a clear only resets the valid bits.
// Depends on cll_pkg and cll_ram.
module cll_link_store (
  input  logic                           clk,
  input  logic                           rst,
  input  cll_pkg::link_req_t             req,
  output logic [cll_pkg::LINK_W-1:0]     rd_data
);
  import cll_pkg::*;

  logic [SLOTS-1:0]  valid;
  logic              rd_valid;
  logic [SLOT_W-1:0] rd_addr_q;
  logic [LINK_W-1:0] ram_data;

  cll_ram #(
    .WIDTH (LINK_W),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (req.wr_en),
    .wr_addr (req.wr_addr),
    .wr_data (req.wr_data),
    .rd_en   (req.rd_en),
    .rd_addr (req.rd_addr),
    .rd_data (ram_data)
  );

  always_ff @(posedge clk) begin
    if (rst || req.clear) begin
      valid <= '0;
    end else if (req.wr_en) begin
      valid[req.wr_addr] <= 1'b1;
    end
    if (req.rd_en) begin
      rd_valid  <= valid[req.rd_addr];
      rd_addr_q <= req.rd_addr;
    end
  end

  always_comb begin
    if (rd_valid) begin
      rd_data = ram_data;
    end else if (rd_addr_q == '0) begin
      rd_data = END_MARK;
    end else begin
      rd_data = FREE_MARK;
    end
  end

endmodule

// ===== src/cursor_linked_list_engine.sv =====
// Channel  | Dir | Beat carries
// request  | in  | operation, position, value
// result   | out | status, removed_value, list_length, is_empty
//
// One request is worked on at a time; insert runs a free-slot scan then a list walk (one
// link-RAM read per cycle), delete a list walk; clear, unused codes and position-zero
// requests go straight to the result state.
// Synchronous active-high reset empties the list via valid bits.
// A new request is taken while the previous result still waits in the output
// register; a stalled result holds the engine only in its final step.
// Depends on cll_pkg, cll_in_if, cll_out_if, cll_ram and cll_link_store.
module cursor_linked_list_engine (
  input  logic      clk,
  input  logic      rst,
  cll_in_if.sink    request,
  cll_out_if.source result
);
  import cll_pkg::*;

  state_t            state, state_next;
  link_req_t         link_req;
  logic [LINK_W-1:0] link_rd;

  logic              val_wr_en;
  logic              val_rd_en;
  logic [VAL_W-1:0]  val_rd;

  op_t               op_r;
  logic [VAL_W-1:0]  val_r;
  logic [POS_W-1:0]  target;
  logic [SLOT_W:0]   scan;
  logic              chk_valid;
  logic [SLOT_W-1:0] chk_slot;
  logic [SLOT_W-1:0] free_slot;
  logic [SLOT_W-1:0] cur;
  logic [LINK_W-1:0] raw_cur;
  logic [SLOT_W-1:0] nxt;
  logic              w_pend;
  logic [POS_W-1:0]  steps;
  logic [CNT_W-1:0]  count;
  logic [LINK_W-1:0] head_raw;
  status_t           status_r;
  logic [VAL_W-1:0]  removed_r;

  logic              accept;
  logic              out_load;
  logic              slot_found;
  logic              store_full;
  logic [LINK_W-1:0] walk_raw;
  logic [LINK_W-1:0] walk_n;
  logic              walk_stop;
  logic              walk_fail;

  cll_link_store u_links (
    .clk     (clk),
    .rst     (rst),
    .req     (link_req),
    .rd_data (link_rd)
  );

  cll_ram #(
    .WIDTH (VAL_W),
    .DEPTH (SLOTS)
  ) u_values (
    .clk     (clk),
    .wr_en   (val_wr_en),
    .wr_addr (free_slot),
    .wr_data (val_r),
    .rd_en   (val_rd_en),
    .rd_addr (walk_n[SLOT_W-1:0]),
    .rd_data (val_rd)
  );

  assign request.ready = (state == S_IDLE);
  assign accept        = request.valid && request.ready;
  assign out_load      = (state == S_DONE) && (!result.valid || result.ready);

  assign slot_found = chk_valid && (link_rd == FREE_MARK);
  assign store_full = chk_valid && !slot_found && (chk_slot == SLOT_W'(SLOTS - 1));

  assign walk_raw  = w_pend ? link_rd : raw_cur;
  assign walk_n    = next_of(walk_raw);
  assign walk_stop = (walk_n == END_MARK) || (steps >= target) ||
                     (steps >= POS_W'(SLOTS));
  assign walk_fail = (op_r == OP_INSERT) ? ((walk_n == END_MARK) && (steps != target))
                                         : (walk_n == END_MARK);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    link_req   = '0;
    val_wr_en  = 1'b0;
    val_rd_en  = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (op_t'(request.operation))
            OP_INSERT: begin
              state_next = (request.position == '0) ? S_DONE : S_FREE;
            end
            OP_DELETE: begin
              state_next = (request.position == '0) ? S_DONE : S_WALK;
            end
            OP_CLEAR: begin
              link_req.clear = 1'b1;
              state_next     = S_DONE;
            end
            default: begin
              state_next = S_DONE;
            end
          endcase
        end
      end
      S_FREE: begin
        link_req.rd_en   = (scan < (SLOT_W + 1)'(SLOTS));
        link_req.rd_addr = scan[SLOT_W-1:0];
        if (slot_found) begin
          state_next = S_WALK;
        end else if (store_full) begin
          state_next = S_DONE;
        end
      end
      S_WALK: begin
        if (!walk_stop) begin
          link_req.rd_en   = 1'b1;
          link_req.rd_addr = walk_n[SLOT_W-1:0];
        end else if (walk_fail) begin
          state_next = S_DONE;
        end else if (op_r == OP_INSERT) begin
          state_next = S_INS_A;
        end else begin
          link_req.rd_en   = 1'b1;
          link_req.rd_addr = walk_n[SLOT_W-1:0];
          val_rd_en        = 1'b1;
          state_next       = S_DEL_WR1;
        end
      end
      S_INS_A: begin
        link_req.wr_en   = 1'b1;
        link_req.wr_addr = free_slot;
        link_req.wr_data = raw_cur;
        val_wr_en        = 1'b1;
        state_next       = S_INS_B;
      end
      S_INS_B: begin
        link_req.wr_en   = 1'b1;
        link_req.wr_addr = cur;
        link_req.wr_data = LINK_W'(free_slot);
        state_next       = S_DONE;
      end
      S_DEL_WR1: begin
        link_req.wr_en   = 1'b1;
        link_req.wr_addr = cur;
        link_req.wr_data = link_rd;
        state_next       = S_DEL_WR2;
      end
      S_DEL_WR2: begin
        link_req.wr_en   = 1'b1;
        link_req.wr_addr = nxt;
        link_req.wr_data = FREE_MARK;
        state_next       = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      head_raw <= END_MARK;
    end else if (link_req.clear) begin
      count    <= '0;
      head_raw <= END_MARK;
    end else begin
      if (link_req.wr_en && link_req.wr_addr == '0) begin
        head_raw <= link_req.wr_data;
      end
      if (state == S_INS_B) begin
        count <= count + CNT_W'(1);
      end else if (state == S_DEL_WR2 && count != '0) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          op_r      <= op_t'(request.operation);
          val_r     <= request.value;
          target    <= request.position - POS_W'(1);
          scan      <= (SLOT_W + 1)'(1);
          chk_valid <= 1'b0;
          cur       <= '0;
          raw_cur   <= head_raw;
          w_pend    <= 1'b0;
          steps     <= '0;
          removed_r <= '0;
          if (request.position == '0 &&
              (op_t'(request.operation) == OP_INSERT ||
               op_t'(request.operation) == OP_DELETE)) begin
            status_r <= ST_POS_ZERO;
          end else begin
            status_r <= ST_OK;
          end
        end
      end
      S_FREE: begin
        chk_valid <= (scan < (SLOT_W + 1)'(SLOTS));
        chk_slot  <= scan[SLOT_W-1:0];
        scan      <= scan + (SLOT_W + 1)'(1);
        if (slot_found) begin
          free_slot <= chk_slot;
        end else if (store_full) begin
          status_r <= ST_FULL;
        end
      end
      S_WALK: begin
        if (!walk_stop) begin
          cur    <= walk_n[SLOT_W-1:0];
          steps  <= steps + POS_W'(1);
          w_pend <= 1'b1;
        end else begin
          raw_cur <= walk_raw;
          nxt     <= walk_n[SLOT_W-1:0];
          if (walk_fail) begin
            status_r <= ST_BEYOND;
          end
        end
      end
      S_DEL_WR1: begin
        removed_r <= val_rd;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (out_load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result.status        <= status_r;
      result.removed_value <= removed_r;
      result.list_length   <= count;
      result.is_empty      <= (next_of(head_raw) == END_MARK);
    end
  end

`ifndef SYNTH
  a_head_never_free: assert property (@(posedge clk) disable iff (rst)
    head_raw != FREE_MARK)
    else $error("head link holds the free mark");

  a_no_rw_collision: assert property (@(posedge clk) disable iff (rst)
    !(link_req.wr_en && link_req.rd_en && link_req.wr_addr == link_req.rd_addr))
    else $error("link store read and write hit the same slot");

  a_walk_bounded: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> (steps <= POS_W'(SLOTS)))
    else $error("list walk ran past the store size");

  a_count_matches_head: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> ((count == '0) == (next_of(head_raw) == END_MARK)))
    else $error("element count disagrees with head link");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != S_IDLE))
    else $error("accepted request did not start");
`endif

endmodule
